### src/bhbt_pkg.sv
package bhbt_pkg;

   localparam int DATA_W          = 64;
   localparam int IDX_W           = 8;
   localparam int CSR_IDX_W       = 2;
   localparam int MAX_ADDR_W      = 17;
   localparam int BUFFER_ENTRIES_DEF = 256;

   // Pipeline stage bits used to build the register reset values
   localparam logic [DATA_W-1:0] STAGE_TOP_OF_PIPE    = 64'h0000_0000_0000_0001;
   localparam logic [DATA_W-1:0] STAGE_DRAW_INDIRECT  = 64'h0000_0000_0000_0002;
   localparam logic [DATA_W-1:0] STAGE_COMPUTE_SHADER = 64'h0000_0000_0000_0800;
   localparam logic [DATA_W-1:0] STAGE_ALL_TRANSFER   = 64'h0000_0000_0000_1000;
   localparam logic [DATA_W-1:0] STAGE_BOTTOM_OF_PIPE = 64'h0000_0000_0000_2000;
   localparam logic [DATA_W-1:0] STAGE_HOST           = 64'h0000_0000_0000_4000;
   localparam logic [DATA_W-1:0] STAGE_ALL_COMMANDS   = 64'h0000_0000_0001_0000;
   localparam logic [DATA_W-1:0] STAGE_COPY           = 64'h0000_0001_0000_0000;
   localparam logic [DATA_W-1:0] STAGE_CLEAR          = 64'h0000_0008_0000_0000;

   localparam logic [DATA_W-1:0] LEGAL_STAGE_RESET =
      STAGE_TOP_OF_PIPE | STAGE_DRAW_INDIRECT | STAGE_COMPUTE_SHADER |
      STAGE_ALL_TRANSFER | STAGE_BOTTOM_OF_PIPE | STAGE_HOST |
      STAGE_ALL_COMMANDS | STAGE_COPY | STAGE_CLEAR;
   localparam logic [DATA_W-1:0] WIDE_STAGE_RESET = STAGE_ALL_COMMANDS;

   typedef enum logic [1:0] {
      CMD_ACCESS = 2'd0,
      CMD_FLUSH  = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMPUTE_ONLY = 2'd0,
      CSR_LEGAL_STAGE  = 2'd1,
      CSR_WIDE_STAGE   = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [DATA_W-1:0] vis_stage;
      logic [DATA_W-1:0] vis_access;
      logic [DATA_W-1:0] reader_stage;
      logic [DATA_W-1:0] wr_stage;
      logic [DATA_W-1:0] wr_access;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic load_flush;
      logic load_zero;
      logic clear_pend;
      logic sweep_wr;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_ok;
      logic sweep_last;
   } dp_status_type;

   function automatic logic [DATA_W-1:0] widen(
      input logic              coq,
      input logic [DATA_W-1:0] s,
      input logic [DATA_W-1:0] legal,
      input logic [DATA_W-1:0] wide
   );
      logic [DATA_W-1:0] r;
      r = s;
      if (coq && (s != '0) && ((s & ~legal) != '0)) begin
         r = (s & legal) | wide;
      end
      return r;
   endfunction

endpackage

### src/bhbt_table.sv
module bhbt_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  bhbt_pkg::entry_type  wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output bhbt_pkg::entry_type  rd_data
);
   import bhbt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bhbt_datapath.sv
module bhbt_datapath #(
   parameter int BUFFER_ENTRIES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bhbt_pkg::dp_cmd_type                 cmd,
   output bhbt_pkg::dp_status_type              status,
   input  logic [bhbt_pkg::IDX_W-1:0]           req_resource_index,
   input  logic [bhbt_pkg::DATA_W-1:0]          req_stage_mask,
   input  logic [bhbt_pkg::DATA_W-1:0]          req_access_mask,
   input  logic                                 req_is_write,
   input  logic                                 csr_wr,
   input  logic [bhbt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bhbt_pkg::DATA_W-1:0]          csr_wdata,
   output logic                                 rsp_barrier_valid,
   output logic [bhbt_pkg::DATA_W-1:0]          rsp_src_stage,
   output logic [bhbt_pkg::DATA_W-1:0]          rsp_src_access,
   output logic [bhbt_pkg::DATA_W-1:0]          rsp_dst_stage,
   output logic [bhbt_pkg::DATA_W-1:0]          rsp_dst_access
);
   import bhbt_pkg::*;

   localparam int AW = $clog2(BUFFER_ENTRIES);

   logic                  coq_ff;
   logic [DATA_W-1:0]     legal_ff;
   logic [DATA_W-1:0]     wide_ff;

   logic [MAX_ADDR_W-1:0] idx_ext;
   logic [AW-1:0]         addr_ff;
   logic [DATA_W-1:0]     stage_ff;
   logic [DATA_W-1:0]     access_ff;
   logic                  write_ff;

   logic [AW-1:0]         sweep_cnt_ff;
   logic [AW-1:0]         sweep_cnt_in;

   logic [DATA_W-1:0]     p_src_stage_ff, p_src_stage_in;
   logic [DATA_W-1:0]     p_src_access_ff, p_src_access_in;
   logic [DATA_W-1:0]     p_dst_stage_ff, p_dst_stage_in;
   logic [DATA_W-1:0]     p_dst_access_ff, p_dst_access_in;

   entry_type             rd_entry;
   entry_type             new_entry;
   entry_type             wr_data;
   logic [AW-1:0]         wr_addr;
   logic                  wr_en;
   logic                  hazard;
   logic [DATA_W-1:0]     hz_src_stage;
   logic                  vis_hit;

   logic                  barrier_valid_ff;
   logic [DATA_W-1:0]     src_stage_ff, src_access_ff, dst_stage_ff, dst_access_ff;

   assign idx_ext = {{(MAX_ADDR_W-IDX_W){1'b0}}, req_resource_index};
   assign status.idx_ok     = idx_ext < MAX_ADDR_W'(BUFFER_ENTRIES);
   assign status.sweep_last = sweep_cnt_ff == AW'(BUFFER_ENTRIES - 1);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coq_ff   <= 1'b0;
         legal_ff <= LEGAL_STAGE_RESET;
         wide_ff  <= WIDE_STAGE_RESET;
      end else if (csr_wr) begin
         case (csr_idx_type'(csr_index))
            CSR_COMPUTE_ONLY: coq_ff   <= csr_wdata[0];
            CSR_LEGAL_STAGE:  legal_ff <= csr_wdata;
            CSR_WIDE_STAGE:   wide_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold the access fields while the entry is read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff   <= idx_ext[AW-1:0];
         stage_ff  <= req_stage_mask;
         access_ff <= req_access_mask;
         write_ff  <= req_is_write;
      end
   end

   bhbt_table #(
      .DEPTH (BUFFER_ENTRIES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (idx_ext[AW-1:0]),
      .rd_data (rd_entry)
   );

   // Hazard check and entry update
   always_comb begin
      vis_hit      = ((rd_entry.vis_stage & stage_ff) == stage_ff) &&
                     ((rd_entry.vis_access & access_ff) == access_ff);
      new_entry    = rd_entry;
      hazard       = 1'b0;
      hz_src_stage = rd_entry.wr_stage;
      if (write_ff) begin
         hazard                 = (rd_entry.wr_access != '0) ||
                                  (rd_entry.reader_stage != '0);
         hz_src_stage           = rd_entry.wr_stage | rd_entry.reader_stage;
         new_entry.wr_stage     = stage_ff;
         new_entry.wr_access    = access_ff;
         new_entry.reader_stage = '0;
         new_entry.vis_stage    = stage_ff;
         new_entry.vis_access   = access_ff;
      end else if (vis_hit) begin
         new_entry.reader_stage = rd_entry.reader_stage | stage_ff;
      end else begin
         hazard                 = rd_entry.wr_access != '0;
         new_entry.reader_stage = rd_entry.reader_stage | stage_ff;
         new_entry.vis_stage    = rd_entry.vis_stage | stage_ff;
         new_entry.vis_access   = rd_entry.vis_access | access_ff;
      end
   end

   always_comb begin
      wr_en   = cmd.update | cmd.sweep_wr;
      wr_addr = cmd.sweep_wr ? sweep_cnt_ff : addr_ff;
      wr_data = cmd.sweep_wr ? entry_type'('0) : new_entry;
   end

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep_wr) begin
         sweep_cnt_in = status.sweep_last ? '0 : sweep_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // Pending barrier
   always_comb begin
      p_src_stage_in  = p_src_stage_ff;
      p_src_access_in = p_src_access_ff;
      p_dst_stage_in  = p_dst_stage_ff;
      p_dst_access_in = p_dst_access_ff;
      if (cmd.clear_pend || (cmd.load_flush && (p_dst_stage_ff != '0))) begin
         p_src_stage_in  = '0;
         p_src_access_in = '0;
         p_dst_stage_in  = '0;
         p_dst_access_in = '0;
      end else if (cmd.update && hazard) begin
         p_src_stage_in  = p_src_stage_ff | hz_src_stage;
         p_src_access_in = p_src_access_ff | rd_entry.wr_access;
         p_dst_stage_in  = p_dst_stage_ff | stage_ff;
         p_dst_access_in = p_dst_access_ff | access_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_src_stage_ff  <= '0;
         p_src_access_ff <= '0;
         p_dst_stage_ff  <= '0;
         p_dst_access_ff <= '0;
      end else begin
         p_src_stage_ff  <= p_src_stage_in;
         p_src_access_ff <= p_src_access_in;
         p_dst_stage_ff  <= p_dst_stage_in;
         p_dst_access_ff <= p_dst_access_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.load_flush && (p_dst_stage_ff != '0)) begin
         barrier_valid_ff <= 1'b1;
         src_stage_ff     <= widen(coq_ff, p_src_stage_ff, legal_ff, wide_ff);
         src_access_ff    <= p_src_access_ff;
         dst_stage_ff     <= widen(coq_ff, p_dst_stage_ff, legal_ff, wide_ff);
         dst_access_ff    <= p_dst_access_ff;
      end else if (cmd.load_flush || cmd.load_zero) begin
         barrier_valid_ff <= 1'b0;
         src_stage_ff     <= '0;
         src_access_ff    <= '0;
         dst_stage_ff     <= '0;
         dst_access_ff    <= '0;
      end
   end

   assign rsp_barrier_valid = barrier_valid_ff;
   assign rsp_src_stage     = src_stage_ff;
   assign rsp_src_access    = src_access_ff;
   assign rsp_dst_stage     = dst_stage_ff;
   assign rsp_dst_access    = dst_access_ff;

endmodule

### src/bhbt_ctrl.sv
module bhbt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bhbt_pkg::dp_cmd_type     cmd,
   input  bhbt_pkg::dp_status_type  status
);
   import bhbt_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_ACCESS = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_ACCESS: begin
                     if (status.idx_ok) begin
                        cmd.capture = 1'b1;
                        state_in    = ST_ACCESS;
                     end else begin
                        cmd.load_zero = 1'b1;
                     end
                  end
                  CMD_FLUSH: cmd.load_flush = 1'b1;
                  CMD_CLEAR: begin
                     cmd.load_zero  = 1'b1;
                     cmd.clear_pend = 1'b1;
                     state_in       = ST_SWEEP;
                  end
                  default: cmd.load_zero = 1'b1;
               endcase
            end
         end
         ST_ACCESS: begin
            cmd.update    = 1'b1;
            cmd.load_zero = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_flush | cmd.load_zero | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_access_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACCESS |=> state_ff == ST_IDLE)
      else $error("access state lasted more than one cycle");

   a_access_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACCESS |-> !rsp_valid_ff)
      else $error("result slot occupied during entry update");

   a_accept_yields_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff || state_ff == ST_ACCESS)
      else $error("accepted transaction produced no result");

endmodule

### src/buffer_hazard_barrier_tracker_unit.sv
// Flush, clear and unknown commands present their result in the cycle after
// acceptance; an access reads its entry then registers its (all-zero) result
// in the read-modify-write state, taking no request meanwhile. One flush per
// cycle while responses are not stalled. A clear is followed by a clearing pass
// over every entry. Reset (synchronous, active high) zeroes the pending barrier
// and starts the same pass; no request is taken until it ends.
module buffer_hazard_barrier_tracker_unit #(
   parameter int BUFFER_ENTRIES = bhbt_pkg::BUFFER_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [bhbt_pkg::IDX_W-1:0]        req_resource_index,
   input  logic [bhbt_pkg::DATA_W-1:0]       req_stage_mask,
   input  logic [bhbt_pkg::DATA_W-1:0]       req_access_mask,
   input  logic                              req_is_write,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_barrier_valid,
   output logic [bhbt_pkg::DATA_W-1:0]       rsp_src_stage,
   output logic [bhbt_pkg::DATA_W-1:0]       rsp_src_access,
   output logic [bhbt_pkg::DATA_W-1:0]       rsp_dst_stage,
   output logic [bhbt_pkg::DATA_W-1:0]       rsp_dst_access,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bhbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bhbt_pkg::DATA_W-1:0]       csr_wdata
);
   import bhbt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers take a write in any cycle; software must see that it
   // writes them only while the tracker is idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   // The controller sequences each transaction: an access reads its table
   // entry in the accept cycle and writes the updated entry back in the next,
   // so the following access always sees the fresh record. A clear restarts
   // the clearing pass, which rewrites every entry to zero so that a forgotten
   // buffer reads as never used.
   bhbt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status)
   );

   // The datapath holds the per-buffer table, the hazard logic, the four
   // pending barrier registers, stage widening and the response payload.
   bhbt_datapath #(
      .BUFFER_ENTRIES (BUFFER_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_resource_index (req_resource_index),
      .req_stage_mask     (req_stage_mask),
      .req_access_mask    (req_access_mask),
      .req_is_write       (req_is_write),
      .csr_wr             (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_barrier_valid  (rsp_barrier_valid),
      .rsp_src_stage      (rsp_src_stage),
      .rsp_src_access     (rsp_src_access),
      .rsp_dst_stage      (rsp_dst_stage),
      .rsp_dst_access     (rsp_dst_access)
   );

endmodule

### tb/sv/tb_buffer_hazard_barrier_tracker_unit.sv
module tb_buffer_hazard_barrier_tracker_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bhbt_pkg::*;

   localparam int          ENTRIES      = BUFFER_ENTRIES_DEF;
   localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;
   localparam logic [63:0] ONES         = '1;
   localparam int          PHASES       = 5;
   localparam int          PHASE_ITEMS  = 115;
   localparam int          HOLD_AT      = 200;   // responses seen before the long hold-off
   localparam int          HOLD_CYCLES  = 400;
   localparam int          STALL_LIMIT  = 4000;  // cycles with no transaction at all
   localparam int          DRAIN_CYCLES = 4;

   typedef struct packed {
      logic        valid;
      logic [63:0] from_stage;
      logic [63:0] from_access;
      logic [63:0] to_stage;
      logic [63:0] to_access;
   } barrier_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  idx;
      logic [63:0] stage;
      logic [63:0] acc;
      logic        wr;
   } txn_type;

   // One directed row: the command, then whether its barrier is typed in here
   // and, if so, the barrier itself.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  idx;
      logic [63:0] stage;
      logic [63:0] acc;
      logic        wr;
      logic        typed;
      logic        b_valid;
      logic [63:0] ss;
      logic [63:0] sa;
      logic [63:0] ds;
      logic [63:0] da;
   } row_type;

   localparam logic [63:0] NAMED_STAGES [9] = '{
      STAGE_TOP_OF_PIPE, STAGE_DRAW_INDIRECT, STAGE_COMPUTE_SHADER,
      STAGE_ALL_TRANSFER, STAGE_BOTTOM_OF_PIPE, STAGE_HOST,
      STAGE_ALL_COMMANDS, STAGE_COPY, STAGE_CLEAR
   };

   // Directed walk. Rows typed 0 take their barrier from the tracker model.
   localparam row_type DIRECTED_ROWS [23] = '{
      // flush straight after reset: nothing pending
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // unknown command with every field at its top value
      '{CMD_UNKNOWN, 8'hff,  ONES,  ONES,  1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // write then read of entry 0: read-after-write hazard
      '{CMD_ACCESS,  8'd0,   STAGE_COMPUTE_SHADER, 64'h40, 1'b1,
        1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'd0,   STAGE_TOP_OF_PIPE,    64'h20, 1'b0,
        1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0,
        1'b1, 1'b1, STAGE_COMPUTE_SHADER, 64'h40, STAGE_TOP_OF_PIPE, 64'h20},
      // same read again is already visible, so the next flush is empty
      '{CMD_ACCESS,  8'd0,   STAGE_TOP_OF_PIPE,    64'h20, 1'b0,
        1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // write-after-read with all-ones masks, then write-after-write with zero masks
      '{CMD_ACCESS,  8'd0,   ONES,  ONES,  1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'd0,   64'h0, 64'h0, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // top entry: fresh write, then visible reads with zero and full masks
      '{CMD_ACCESS,  8'hff,  ONES,  ONES,  1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'hff,  64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'hff,  ONES,  ONES,  1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // clear forgets every entry and the pending barrier
      '{CMD_CLEAR,   8'h5a,  ONES,  ONES,  1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'hff,  ONES,  ONES,  1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // read on a forgotten entry, then write-after-read on it
      '{CMD_ACCESS,  8'hff,  ONES,  ONES,  1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'hff,  STAGE_HOST, 64'h8000, 1'b1,
        1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      // hazard with zero destination stage: flush keeps the pending masks
      '{CMD_ACCESS,  8'd7,   STAGE_COPY, 64'h1000, 1'b1,
        1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'd7,   64'h0, 64'h800, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_ACCESS,  8'd7,   STAGE_CLEAR, 64'h2, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{CMD_FLUSH,   8'd0,   64'h0, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0}
   };

   // Clock, reset and block ports; every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_ACCESS;
   logic [7:0]  req_resource_index = '0;
   logic [63:0] req_stage_mask = '0;
   logic [63:0] req_access_mask = '0;
   logic        req_is_write = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_barrier_valid;
   logic [63:0] rsp_src_stage;
   logic [63:0] rsp_src_access;
   logic [63:0] rsp_dst_stage;
   logic [63:0] rsp_dst_access;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Tracker model: configuration, per-buffer records and pending barrier.
   logic        cfg_compute_only;
   logic [63:0] cfg_legal;
   logic [63:0] cfg_wide;
   logic        in_use      [ENTRIES];
   logic [63:0] seen_stage  [ENTRIES];
   logic [63:0] seen_access [ENTRIES];
   logic [63:0] readers     [ENTRIES];
   logic [63:0] wr_stage    [ENTRIES];
   logic [63:0] wr_access   [ENTRIES];
   logic [63:0] pend_src_stage;
   logic [63:0] pend_src_access;
   logic [63:0] pend_dst_stage;
   logic [63:0] pend_dst_access;

   barrier_type barrier_queue[$];   // barriers owed by the block, oldest first
   txn_type     last_access;
   logic        have_last_access = 1'b0;
   logic        quiet_sender = 1'b0;
   int          errors = 0;
   int          idle_cycles = 0;
   int          rsp_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          stall_left = 0;

   buffer_hazard_barrier_tracker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_resource_index (req_resource_index),
      .req_stage_mask     (req_stage_mask),
      .req_access_mask    (req_access_mask),
      .req_is_write       (req_is_write),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_barrier_valid  (rsp_barrier_valid),
      .rsp_src_stage      (rsp_src_stage),
      .rsp_src_access     (rsp_src_access),
      .rsp_dst_stage      (rsp_dst_stage),
      .rsp_dst_access     (rsp_dst_access),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drop every record and the pending barrier.
   function automatic void forget_tracking();
      for (int i = 0; i < ENTRIES; i++) begin
         in_use[i]      = 1'b0;
         seen_stage[i]  = '0;
         seen_access[i] = '0;
         readers[i]     = '0;
         wr_stage[i]    = '0;
         wr_access[i]   = '0;
      end
      pend_src_stage  = '0;
      pend_src_access = '0;
      pend_dst_stage  = '0;
      pend_dst_access = '0;
   endfunction

   // Widen a stage mask that names stages a compute-only queue cannot.
   function automatic logic [63:0] promote_stage(input logic [63:0] s);
      if (!cfg_compute_only || s == '0 || (s & ~cfg_legal) == '0) begin
         return s;
      end
      return (s & cfg_legal) | cfg_wide;
   endfunction

   // Advance the tracker model by one command and return the barrier it yields.
   function automatic barrier_type track_command(input txn_type t);
      barrier_type b;
      int          i;
      b = '0;
      i = t.idx;
      case (t.cmd)
         CMD_ACCESS: begin
            if (i < ENTRIES) begin
               if (!in_use[i]) begin
                  in_use[i]      = 1'b1;
                  seen_stage[i]  = '0;
                  seen_access[i] = '0;
                  readers[i]     = '0;
                  wr_stage[i]    = '0;
                  wr_access[i]   = '0;
               end
               if (!t.wr) begin
                  if ((seen_stage[i] & t.stage) == t.stage &&
                      (seen_access[i] & t.acc) == t.acc) begin
                     // already visible: only note the reader
                     readers[i] |= t.stage;
                  end else begin
                     if (wr_access[i] != '0) begin
                        pend_src_stage  |= wr_stage[i];
                        pend_src_access |= wr_access[i];
                        pend_dst_stage  |= t.stage;
                        pend_dst_access |= t.acc;
                     end
                     readers[i]     |= t.stage;
                     seen_stage[i]  |= t.stage;
                     seen_access[i] |= t.acc;
                  end
               end else begin
                  if (wr_access[i] != '0 || readers[i] != '0) begin
                     pend_src_stage  |= wr_stage[i] | readers[i];
                     pend_src_access |= wr_access[i];
                     pend_dst_stage  |= t.stage;
                     pend_dst_access |= t.acc;
                  end
                  wr_stage[i]    = t.stage;
                  wr_access[i]   = t.acc;
                  readers[i]     = '0;
                  seen_stage[i]  = t.stage;
                  seen_access[i] = t.acc;
               end
            end
         end
         CMD_FLUSH: begin
            if (pend_dst_stage != '0) begin
               b.valid         = 1'b1;
               b.from_stage    = promote_stage(pend_src_stage);
               b.from_access   = pend_src_access;
               b.to_stage      = promote_stage(pend_dst_stage);
               b.to_access     = pend_dst_access;
               pend_src_stage  = '0;
               pend_src_access = '0;
               pend_dst_stage  = '0;
               pend_dst_access = '0;
            end
         end
         CMD_CLEAR: forget_tracking();
         default: ;
      endcase
      return b;
   endfunction

   // Gap length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) begin
         return 0;
      end
      if (r < 18) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] pick_stage();
      logic [63:0] s;
      case ($urandom_range(0, 4))
         0:       s = NAMED_STAGES[$urandom_range(0, 8)];
         1:       s = NAMED_STAGES[$urandom_range(0, 8)] | NAMED_STAGES[$urandom_range(0, 8)];
         2:       s = {$urandom, $urandom};
         3:       s = 64'd1 << $urandom_range(0, 63);
         default: s = NAMED_STAGES[$urandom_range(0, 8)] | (64'd1 << $urandom_range(0, 63));
      endcase
      return s;
   endfunction

   function automatic logic [63:0] pick_access();
      logic [63:0] a;
      case ($urandom_range(0, 7))
         0:       a = '0;
         1, 2:    a = {$urandom, $urandom};
         3:       a = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
         default: a = 64'd1 << $urandom_range(0, 63);
      endcase
      return a;
   endfunction

   // Random command: mostly accesses on a handful of buffers so that hazards
   // recur, with flushes, the odd clear, unknown commands and re-reads.
   function automatic txn_type random_txn();
      txn_type t;
      int      r;
      t.cmd   = CMD_ACCESS;
      t.idx   = 8'($urandom_range(0, 255));
      t.stage = {$urandom, $urandom};
      t.acc   = {$urandom, $urandom};
      t.wr    = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 3) begin
         t.cmd = CMD_CLEAR;
      end else if (r < 6) begin
         t.cmd = CMD_UNKNOWN;
      end else if (r < 26) begin
         t.cmd = CMD_FLUSH;
      end else begin
         if ($urandom_range(0, 9) < 7) begin
            t.idx = 8'($urandom_range(0, 7));
         end
         t.stage = pick_stage();
         t.acc   = pick_access();
         t.wr    = ($urandom_range(0, 9) < 4);
         // re-read part of the last access so that visible reads occur
         if (!t.wr && have_last_access && $urandom_range(0, 3) == 0) begin
            t.idx   = last_access.idx;
            t.stage = last_access.stage & {$urandom, $urandom};
            t.acc   = last_access.acc & {$urandom, $urandom};
         end
         last_access      = t;
         have_last_access = 1'b1;
      end
      return t;
   endfunction

   // Offer one command, hold it until the block takes it, then idle at random.
   // Valid stays high across back-to-back transactions.
   task automatic send_txn(input txn_type t, input logic typed, input barrier_type fixed);
      barrier_type b;
      int          gap;
      req_command        <= t.cmd;
      req_resource_index <= t.idx;
      req_stage_mask     <= t.stage;
      req_access_mask    <= t.acc;
      req_is_write       <= t.wr;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      b = track_command(t);
      barrier_queue.push_back(typed ? fixed : b);
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lower valid and wait for every owed barrier.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (barrier_queue.size() != 0) @(posedge clock);
   endtask

   // One register write; valid is left high for a following write.
   task automatic write_csr(input csr_idx_type idx, input logic [63:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COMPUTE_ONLY: cfg_compute_only = value[0];
         CSR_LEGAL_STAGE:  cfg_legal        = value;
         CSR_WIDE_STAGE:   cfg_wide         = value;
         default: ;
      endcase
   endtask

   // Response side: retire each accepted transaction against the oldest owed
   // barrier, then decide the stall for the next cycle. Sampling happens
   // before the block's own updates of this edge land, so values are stable.
   always @(posedge clock) begin : rsp_side
      barrier_type got;
      barrier_type want;
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got = '{rsp_barrier_valid, rsp_src_stage, rsp_src_access,
                 rsp_dst_stage, rsp_dst_access};
         rsp_count++;
         if (barrier_queue.size() == 0) begin
            $display("%0t: response with nothing owed: v=%0b src %h/%h dst %h/%h",
                     $time, got.valid, got.from_stage, got.from_access,
                     got.to_stage, got.to_access);
            errors++;
         end else begin
            want = barrier_queue.pop_front();
            if (got !== want) begin
               $display("%0t: barrier mismatch: expected v=%0b src %h/%h dst %h/%h",
                        $time, want.valid, want.from_stage, want.from_access,
                        want.to_stage, want.to_access);
               $display("%0t:                   actual   v=%0b src %h/%h dst %h/%h",
                        $time, got.valid, got.from_stage, got.from_access,
                        got.to_stage, got.to_access);
               errors++;
            end
         end
      end
      // Hold off once for a long stretch so the block backs up into its input;
      // otherwise stall at random, with quiet stretches.
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ((rsp_count / 90) % 4 != 1) begin
            stall_left = pick_gap();
         end
      end
   end

   // Count cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("buffer_hazard_barrier_tracker_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      row_type     row;
      txn_type     t;
      barrier_type fixed;
      logic [63:0] coq_word;
      logic [63:0] legal_word;
      logic [63:0] wide_word;

      cfg_compute_only = 1'b0;
      cfg_legal        = LEGAL_STAGE_RESET;
      cfg_wide         = WIDE_STAGE_RESET;
      forget_tracking();

      // Hold reset, then release it; the block then runs its clearing pass and
      // holds off the input until that is done.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed walk under the reset configuration.
      for (int n = 0; n < $size(DIRECTED_ROWS); n++) begin
         row   = DIRECTED_ROWS[n];
         t     = '{row.cmd, row.idx, row.stage, row.acc, row.wr};
         fixed = '{row.b_valid, row.ss, row.sa, row.ds, row.da};
         send_txn(t, row.typed, fixed);
      end
      wait_idle();

      // Random phases, each under its own configuration, written while idle:
      // reset masks widened, no widening, widen everything, then random masks
      // with and without the compute-only queue.
      for (int phase = 1; phase <= PHASES; phase++) begin
         coq_word   = {$urandom, $urandom};
         coq_word[0] = (phase != PHASES);
         case (phase)
            1: begin
               legal_word = LEGAL_STAGE_RESET;
               wide_word  = WIDE_STAGE_RESET;
            end
            2: begin
               legal_word = ONES;
               wide_word  = '0;
            end
            3: begin
               legal_word = '0;
               wide_word  = ONES;
            end
            default: begin
               legal_word = {$urandom, $urandom};
               wide_word  = {$urandom, $urandom};
            end
         endcase
         write_csr(CSR_COMPUTE_ONLY, coq_word);
         write_csr(CSR_LEGAL_STAGE, legal_word);
         write_csr(CSR_WIDE_STAGE, wide_word);
         csr_valid <= 1'b0;

         quiet_sender = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_txn(random_txn(), 1'b0, '0);
         end
         // pause the input until the block has delivered everything
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("buffer_hazard_barrier_tracker_unit regression: pass");
      end else begin
         $display("buffer_hazard_barrier_tracker_unit regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
src/bhbt_pkg.sv
src/bhbt_table.sv
src/bhbt_datapath.sv
src/bhbt_ctrl.sv
src/buffer_hazard_barrier_tracker_unit.sv
tb/sv/tb_buffer_hazard_barrier_tracker_unit.sv
